// ----- hw/rtl/uer_pkg.sv -----
// shared types and constants for the ultrasonic echo ranging core
package uer_pkg;

  localparam int unsigned TrigW   = 8;
  localparam int unsigned RiseW   = 17;
  localparam int unsigned EchoW   = 16;
  localparam int unsigned DistW   = 14;
  localparam int unsigned ScaleW  = 16;
  localparam int unsigned CountW  = 17;
  localparam int unsigned AccW    = EchoW + ScaleW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 17;

  localparam logic [TrigW-1:0]  TrigTicksRst   = 8'd10;
  localparam logic [RiseW-1:0]  RiseTimeoutRst = 17'd100000;
  localparam logic [EchoW-1:0]  EchoTimeoutRst = 16'd40000;
  localparam logic [DistW-1:0]  MaxDistRst     = 14'd6000;
  localparam logic [ScaleW-1:0] MmPerTickRst   = 16'd11141;

  localparam logic [CfgIdxW-1:0] CFG_TRIGGER_TICKS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RISE_TIMEOUT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ECHO_TIMEOUT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DISTANCE  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MM_PER_TICK   = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_RISE = 4'b0100,
    PH_HIGH = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ECHO  = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef struct packed {
    logic             trig;
    logic             busy_res;
    logic             done_res;
    logic [DistW-1:0] distance_mm;
    status_t          status;
  } out_beat_t;

endpackage

// ----- hw/rtl/ultrasonic_echo_ranging_core.sv -----
// ultrasonic echo ranging controller: trigger, echo timing, scaling and result buffer
//
// One input beat per 1 us tick carries start_req and the sampled echo level.
// Every accepted input beat yields exactly one output beat with the trigger
// level to drive, busy, done, distance_mm and status for that tick.
// Channels use valid/stall; a beat moves on a clock edge with valid high and
// stall low. Input beats are taken one per cycle while in_stall is low; the
// result of a beat is in the output buffer the cycle after it is accepted.
// On the tick the echo falls, the counted width is multiplied by the scale
// factor (16 by 16 bits) and compared with the distance limit, all between
// the state registers and the result buffer.
// A two-entry output buffer decouples the sides: input stall rises only when
// both entries hold beats the receiver has not yet taken, so input is still
// accepted while one finished beat waits under a receiver stall.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered and
// apply from the next tick, also in the middle of a measurement; unknown
// indexes are ignored.
// Synchronous reset returns the controller to idle, empties the output buffer
// and loads the default register values.
module ultrasonic_echo_ranging_core
  import uer_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               start_req,
  input  logic               echo,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               trig,
  output logic               busy_res,
  output logic               done_res,
  output logic [DistW-1:0]   distance_mm,
  output logic [1:0]         status
);

  // configuration registers
  logic [TrigW-1:0]  trigger_ticks;
  logic [RiseW-1:0]  rise_timeout_ticks;
  logic [EchoW-1:0]  echo_timeout_ticks;
  logic [DistW-1:0]  max_distance_mm;
  logic [ScaleW-1:0] mm_per_tick_q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks      <= TrigTicksRst;
      rise_timeout_ticks <= RiseTimeoutRst;
      echo_timeout_ticks <= EchoTimeoutRst;
      max_distance_mm    <= MaxDistRst;
      mm_per_tick_q16    <= MmPerTickRst;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRIGGER_TICKS: trigger_ticks      <= cfg_data[TrigW-1:0];
        CFG_RISE_TIMEOUT:  rise_timeout_ticks <= cfg_data[RiseW-1:0];
        CFG_ECHO_TIMEOUT:  echo_timeout_ticks <= cfg_data[EchoW-1:0];
        CFG_MAX_DISTANCE:  max_distance_mm    <= cfg_data[DistW-1:0];
        CFG_MM_PER_TICK:   mm_per_tick_q16    <= cfg_data[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // measurement state
  phase_t            phase, phase_next;
  logic [CountW-1:0] tick_count, tick_count_next;

  logic [1:0]        count;
  out_beat_t         slot0, slot1;
  out_beat_t         beat;

  logic push, pop;
  assign push = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;

  logic [TrigW-1:0]  trig_len;
  logic [RiseW-1:0]  rise_len;
  logic [CountW-1:0] rise_base, rise_inc, high_inc;
  logic [AccW-1:0]   product;
  logic [EchoW-1:0]  scaled;
  logic              do_rise;

  assign trig_len  = (trigger_ticks == '0) ? TrigW'(1) : trigger_ticks;
  assign rise_len  = (rise_timeout_ticks == '0) ? RiseW'(1) : rise_timeout_ticks;
  // the tick that ends the trigger is already the first rise sample
  assign rise_base = (phase == PH_TRIG) ? '0 : tick_count;
  assign rise_inc  = rise_base + CountW'(1);
  assign high_inc  = tick_count + CountW'(1);
  // in the high phase the width stays below the echo timeout, so 16 bits hold it
  assign product   = tick_count[EchoW-1:0] * mm_per_tick_q16;
  assign scaled    = product[AccW-1:ScaleW];

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    beat            = '0;
    do_rise         = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (start_req) begin
          phase_next      = PH_TRIG;
          tick_count_next = CountW'(1);
          beat.trig       = 1'b1;
          beat.busy_res   = 1'b1;
        end
      end
      PH_TRIG: begin
        if (tick_count < CountW'(trig_len)) begin
          tick_count_next = high_inc;
          beat.trig       = 1'b1;
          beat.busy_res   = 1'b1;
        end else begin
          do_rise = 1'b1;
        end
      end
      PH_RISE: begin
        do_rise = 1'b1;
      end
      PH_HIGH: begin
        if (echo) begin
          if (high_inc >= CountW'(echo_timeout_ticks)) begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
            beat.done_res   = 1'b1;
            beat.status     = ST_TOO_LONG;
          end else begin
            tick_count_next = high_inc;
            beat.busy_res   = 1'b1;
          end
        end else begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          beat.done_res   = 1'b1;
          if (scaled > EchoW'(max_distance_mm)) begin
            beat.status = ST_RANGE;
          end else begin
            beat.status      = ST_OK;
            beat.distance_mm = scaled[DistW-1:0];
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase

    if (do_rise) begin
      if (echo) begin
        if (echo_timeout_ticks <= EchoW'(1)) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          beat.done_res   = 1'b1;
          beat.status     = ST_TOO_LONG;
        end else begin
          phase_next      = PH_HIGH;
          tick_count_next = CountW'(1);
          beat.busy_res   = 1'b1;
        end
      end else if (rise_inc >= CountW'(rise_len)) begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
        beat.done_res   = 1'b1;
        beat.status     = ST_NO_ECHO;
      end else begin
        phase_next      = PH_RISE;
        tick_count_next = rise_inc;
        beat.busy_res   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
    end else if (push) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
    end
  end

  // two-entry output buffer, slot0 is the head
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= slot1;
    end
    if (push) begin
      if (count == 2'd0 || (count == 2'd1 && pop)) begin
        slot0 <= beat;
      end else begin
        slot1 <= beat;
      end
    end
  end

  assign in_stall    = (count == 2'd2);
  assign out_valid   = (count != 2'd0);
  assign trig        = slot0.trig;
  assign busy_res    = slot0.busy_res;
  assign done_res    = slot0.done_res;
  assign distance_mm = slot0.distance_mm;
  assign status      = slot0.status;

  // buffer starts empty after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output buffer not empty after reset");

  // a beat that is not a done beat carries no distance and ok status
  assert property (@(posedge clk) disable iff (rst)
    (push && !beat.done_res) |-> (beat.distance_mm == '0 && beat.status == ST_OK))
    else $error("non-done beat carries a result");

  // a nonzero distance is only reported with ok status
  assert property (@(posedge clk) disable iff (rst)
    (push && beat.distance_mm != '0) |-> (beat.status == ST_OK && beat.done_res))
    else $error("distance reported with failure status");

  // a falling echo in the high phase always finishes the measurement
  assert property (@(posedge clk) disable iff (rst)
    (push && phase == PH_HIGH && !echo) |=> (phase == PH_IDLE && tick_count == '0))
    else $error("echo fall did not finish measurement");

  // done and busy are never both set, and trigger implies busy
  assert property (@(posedge clk) disable iff (rst)
    push |-> (!(beat.done_res && beat.busy_res) && (!beat.trig || beat.busy_res)))
    else $error("inconsistent busy, done and trigger flags");

  // a full buffer keeps both beats until the receiver takes one
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> (count == 2'd2))
    else $error("output buffer count lost a beat");

endmodule

// ----- tb/sv/tb_ultrasonic_echo_ranging_core.sv -----
// testbench for the ultrasonic echo ranging core: tick predictor, scoreboard and stimulus
module tb_ultrasonic_echo_ranging_core;
  timeunit 1ns;
  timeprecision 1ps;
  import uer_pkg::*;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned CycleLimit   = 100_000;

  // per-tick model of the ranging controller plus the queue of beats it predicts
  class range_scoreboard;
    logic [TrigW-1:0]  trig_ticks;
    logic [RiseW-1:0]  rise_to;
    logic [EchoW-1:0]  echo_to;
    logic [DistW-1:0]  max_dist;
    logic [ScaleW-1:0] scale;
    phase_t            phase;
    logic [CountW-1:0] count;
    out_beat_t         expected_beats[$];
    int unsigned       errors;

    function new();
      load_defaults();
      errors = 0;
    endfunction

    function void load_defaults();
      trig_ticks = TrigTicksRst;
      rise_to    = RiseTimeoutRst;
      echo_to    = EchoTimeoutRst;
      max_dist   = MaxDistRst;
      scale      = MmPerTickRst;
      phase      = PH_IDLE;
      count      = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CFG_TRIGGER_TICKS: trig_ticks = data[TrigW-1:0];
        CFG_RISE_TIMEOUT:  rise_to    = data[RiseW-1:0];
        CFG_ECHO_TIMEOUT:  echo_to    = data[EchoW-1:0];
        CFG_MAX_DISTANCE:  max_dist   = data[DistW-1:0];
        CFG_MM_PER_TICK:   scale      = data[ScaleW-1:0];
        default: ;
      endcase
    endfunction

    // zero lengths behave as one
    function logic [CountW-1:0] trig_len();
      return (trig_ticks == 0) ? CountW'(1) : CountW'(trig_ticks);
    endfunction

    function logic [CountW-1:0] rise_len();
      return (rise_to == 0) ? CountW'(1) : CountW'(rise_to);
    endfunction

    function bit in_trigger();
      return (phase == PH_TRIG) && (count < trig_len());
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    function out_beat_t finish(logic [DistW-1:0] dist_mm, status_t st);
      out_beat_t r;
      r = '0;
      r.done_res    = 1'b1;
      r.distance_mm = dist_mm;
      r.status      = st;
      phase = PH_IDLE;
      count = '0;
      return r;
    endfunction

    function void note_tick(bit start, bit echo_lvl);
      out_beat_t                r;
      bit                       rise_sample;
      logic [CountW+ScaleW-1:0] prod;
      logic [CountW-1:0]        scaled;
      r = '0;
      rise_sample = 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            phase = PH_TRIG;
            count = CountW'(1);
            r.trig = 1'b1;
            r.busy_res = 1'b1;
          end
        end
        PH_TRIG: begin
          if (count < trig_len()) begin
            count = count + 1'b1;
            r.trig = 1'b1;
            r.busy_res = 1'b1;
          end else begin
            // trigger over: this tick is already the first rise sample
            phase = PH_RISE;
            count = '0;
            rise_sample = 1'b1;
          end
        end
        PH_RISE: rise_sample = 1'b1;
        default: begin
          if (echo_lvl) begin
            count = count + 1'b1;
            if (count >= echo_to) r = finish('0, ST_TOO_LONG);
            else r.busy_res = 1'b1;
          end else begin
            prod = count * scale;
            scaled = prod[CountW+ScaleW-1:16];
            if (scaled > max_dist) r = finish('0, ST_RANGE);
            else r = finish(scaled[DistW-1:0], ST_OK);
          end
        end
      endcase
      if (rise_sample) begin
        if (echo_lvl) begin
          count = CountW'(1);
          if (count >= echo_to) begin
            r = finish('0, ST_TOO_LONG);
          end else begin
            phase = PH_HIGH;
            r.busy_res = 1'b1;
          end
        end else begin
          count = count + 1'b1;
          if (count >= rise_len()) r = finish('0, ST_NO_ECHO);
          else r.busy_res = 1'b1;
        end
      end
      expected_beats.push_back(r);
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: trig %0d busy %0d done %0d dist %0d st %0d",
               got.trig, got.busy_res, got.done_res, got.distance_mm, got.status);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.trig !== want.trig) begin
        $error("trig: expected %0d, got %0d", want.trig, got.trig);
        errors++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
        errors++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
        errors++;
      end
      if (got.distance_mm !== want.distance_mm) begin
        $error("distance_mm: expected %0d, got %0d", want.distance_mm, got.distance_mm);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               start_req = 1'b0;
  logic               echo = 1'b0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               trig;
  logic               busy_res;
  logic               done_res;
  logic [DistW-1:0]   distance_mm;
  logic [1:0]         status;

  range_scoreboard sb;
  out_beat_t       seen_beat;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     hold_left = 0;
  int unsigned     cycle_count = 0;

  ultrasonic_echo_ranging_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .start_req(start_req),
    .echo(echo),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .trig(trig),
    .busy_res(busy_res),
    .done_res(done_res),
    .distance_mm(distance_mm),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_ultrasonic_echo_ranging_core: FAIL");
      $finish;
    end
  end

  // receiver: a long hold-off wins over the random stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_beat.trig        = trig;
      seen_beat.busy_res    = busy_res;
      seen_beat.done_res    = done_res;
      seen_beat.distance_mm = distance_mm;
      seen_beat.status      = status_t'(status);
      sb.check_beat(seen_beat);
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_item(bit s, bit e);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    start_req = s;
    echo      = e;
    do @(posedge clk); while (in_stall);
    sb.note_tick(s, e);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  // push a running measurement to its end: raise echo while waiting, drop it while high
  task automatic drain_measurement();
    while (sb.phase != PH_IDLE) send_item(1'b0, sb.phase == PH_RISE);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // register value with random junk above its width
  function automatic logic [CfgW-1:0] cfg_word(int unsigned value, int unsigned w);
    logic [CfgW-1:0] mask;
    logic [CfgW-1:0] junk;
    mask = (CfgW'(1) << w) - 1'b1;
    junk = CfgW'($urandom);
    return (junk & ~mask) | (CfgW'(value) & mask);
  endfunction

  task automatic cfg_idle_write(logic [CfgIdxW-1:0] idx, int unsigned value, int unsigned w);
    drain_measurement();
    settle();
    cfg_write(idx, cfg_word(value, w));
  endtask

  task automatic set_all(int unsigned t, int unsigned r, int unsigned e, int unsigned m,
                         int unsigned sc);
    cfg_idle_write(CFG_TRIGGER_TICKS, t, TrigW);
    cfg_idle_write(CFG_RISE_TIMEOUT, r, RiseW);
    cfg_idle_write(CFG_ECHO_TIMEOUT, e, EchoW);
    cfg_idle_write(CFG_MAX_DISTANCE, m, DistW);
    cfg_idle_write(CFG_MM_PER_TICK, sc, ScaleW);
  endtask

  // one measurement: start, trigger, low_ticks quiet samples, high_ticks echo, then fall
  task automatic run_pulse(int unsigned low_ticks, int unsigned high_ticks, bit s_busy);
    int unsigned i;
    send_item(1'b1, 1'b0);
    while (sb.in_trigger()) send_item(s_busy, 1'b1);
    for (i = 0; i < low_ticks; i++) begin
      if (sb.phase == PH_IDLE) break;
      send_item(s_busy, 1'b0);
    end
    for (i = 0; i < high_ticks; i++) begin
      if (sb.phase == PH_IDLE) break;
      send_item(s_busy, 1'b1);
    end
    if (sb.phase == PH_HIGH) send_item(s_busy, 1'b0);
  endtask

  // mostly plausible echo behavior for the current phase, some pure noise
  task automatic random_beat();
    bit s;
    bit e;
    s = 1'($urandom_range(0, 1));
    e = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) >= 12) begin
      case (sb.phase)
        PH_IDLE: s = ($urandom_range(0, 2) == 0);
        PH_RISE: e = ($urandom_range(0, sb.rise_len()) < 2);
        PH_HIGH: e = ($urandom_range(0, sb.echo_to + 1) >= 2);
        default: ;
      endcase
    end
    send_item(s, e);
  endtask

  task automatic random_segment(int unsigned n);
    repeat (n) random_beat();
  endtask

  task automatic random_config();
    int unsigned t;
    int unsigned m;
    int unsigned sc;
    t  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
    m  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 48);
    sc = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 65535);
    set_all(t, $urandom_range(0, 40), $urandom_range(0, 48), m, sc);
    // unknown index must leave every register alone
    cfg_write(CfgIdxW'(CFG_MM_PER_TICK + $urandom_range(1, 3)), CfgW'($urandom));
  endtask

  initial begin
    int unsigned mode;
    sb = new();
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // reset register values, echo and start while idle or busy
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b0);
    run_pulse(3, 20, 1'b1);

    // lowest settings: zero lengths act as one, zero and one echo timeout fail at rise
    set_all(0, 0, 0, 0, 0);
    run_pulse(1, 0, 1'b0);
    run_pulse(0, 1, 1'b0);
    cfg_idle_write(CFG_ECHO_TIMEOUT, 1, EchoW);
    run_pulse(0, 1, 1'b1);
    cfg_idle_write(CFG_ECHO_TIMEOUT, 2, EchoW);
    cfg_idle_write(CFG_MM_PER_TICK, 65535, ScaleW);
    run_pulse(0, 1, 1'b0);
    cfg_idle_write(CFG_ECHO_TIMEOUT, 3, EchoW);
    run_pulse(0, 2, 1'b0);

    // widest settings, then the range edge with the full scale factor
    set_all(255, 131071, 65535, 16383, 65535);
    run_pulse(2, 40, 1'b0);
    set_all(3, 131071, 65535, 20, 65535);
    run_pulse(0, 21, 1'b1);
    run_pulse(1, 22, 1'b0);

    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      repeat (3) begin
        random_config();
        random_segment(90);
      end
    end

    // receiver holds off long enough for the buffer to fill and stall the input
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_config();
    hold_left = 300;
    random_segment(80);
    settle();
    random_segment(60);

    drain_measurement();
    settle();
    if (sb.errors == 0) begin
      $display("tb_ultrasonic_echo_ranging_core: PASS");
    end else begin
      $display("tb_ultrasonic_echo_ranging_core: FAIL");
    end
    $finish;
  end

endmodule
